// ===== rtl/core/stra_pkg.sv =====
package stra_pkg;

	localparam int POS_W       = 10;
	localparam int VAL_W       = 64;
	localparam int LVL_W       = 5;
	localparam int DEPTH_DEF   = 1024;
	localparam int LEVELS_DEF  = 11;
	localparam int QUEUE_DEPTH = 4;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// one classified item as it waits between front and back
	typedef struct packed {
		logic                    req_type;
		logic                    last;
		logic signed [VAL_W-1:0] value;
		logic                    bad;    // left > right
		logic [LVL_W-1:0]        lvl;    // block level k of the query
		logic [POS_W-1:0]        pos_a;  // start of left block
		logic [POS_W-1:0]        pos_b;  // start of right block
		logic [POS_W-1:0]        right;
	} stra_item_t;

endpackage

// ===== rtl/core/sparse_table_range_argmax.sv =====
// Channel  Direction  Handshake            Item
// -------  ---------  -------------------  ------------------------------------------
// in       into       in_valid / in_stall  req_type load_value is_last range_left range_right
// out      out of     out_valid/out_stall  max_position max_value range_error
//
// A four-entry queue takes input items while the back end works, so the input
// stalls only when that queue is full.
// Back end: a load is written as it is popped, a query passes S_Q_RD, S_Q_VAL and
// S_Q_CMP, and an erroring query is answered as it is popped. The item marked last
// builds the table: per level j a check in S_BT_RD, per block S_BT_RD, S_BT_VAL and
// S_BT_WR (two table reads, two value reads, compare and write); loads and queries behind it wait in the queue.
// Reset clears count and ready flag; the value and table memories are not cleared.
// A query result waits in the output register while out_stall is high.
module sparse_table_range_argmax import stra_pkg::*; #(
	parameter int DEPTH  = DEPTH_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    req_type,
	input  logic signed [VAL_W-1:0] load_value,
	input  logic                    is_last,
	input  logic [POS_W-1:0]        range_left,
	input  logic [POS_W-1:0]        range_right,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [POS_W-1:0]        max_position,
	output logic signed [VAL_W-1:0] max_value,
	output logic                    range_error
);

	stra_item_t push_item;
	stra_item_t head_item;
	logic       push;
	logic       full;
	logic       pop;
	logic       not_empty;

	// front: left/right order check, block level and block starts of each query
	stra_front #(.LEVELS(LEVELS)) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.load_value  (load_value),
		.is_last     (is_last),
		.range_left  (range_left),
		.range_right (range_right),
		.q_full      (full),
		.q_push      (push),
		.q_item      (push_item)
	);

	stra_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head_item)
	);

	// back: memories, table build sequencer, query lookup
	stra_back #(.DEPTH(DEPTH), .LEVELS(LEVELS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (not_empty),
		.q_item       (head_item),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.max_position (max_position),
		.max_value    (max_value),
		.range_error  (range_error)
	);

endmodule

// ===== rtl/core/stra_front.sv =====
module stra_front import stra_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    req_type,
	input  logic signed [VAL_W-1:0] load_value,
	input  logic                    is_last,
	input  logic [POS_W-1:0]        range_left,
	input  logic [POS_W-1:0]        range_right,
	input  logic                    q_full,
	output logic                    q_push,
	output stra_item_t              q_item
);

	logic [POS_W:0]   len;
	logic [LVL_W-1:0] k;
	logic [31:0]      b_start;

	always_comb begin
		len = {1'b0, range_right} - {1'b0, range_left} + (POS_W+1)'(1);
		k = '0;
		for (int j = 1; j < LEVELS; j++) begin
			if ((32'd1 << j) <= 32'(len)) k = LVL_W'(j);
		end
		b_start = 32'(range_right) + 32'd1 - (32'd1 << k);
	end

	always_comb begin
		q_item.req_type = req_type;
		q_item.last     = is_last;
		q_item.value    = load_value;
		q_item.bad      = range_left > range_right;
		q_item.lvl      = k;
		q_item.pos_a    = range_left;
		q_item.pos_b    = b_start[POS_W-1:0];
		q_item.right    = range_right;
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

endmodule

// ===== rtl/core/stra_queue.sv =====
module stra_queue import stra_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  stra_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output stra_item_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	stra_item_t      slots_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     fill_q;

	assign full      = fill_q == (PW+1)'(QUEUE_DEPTH);
	assign not_empty = fill_q != '0;
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)      fill_q <= fill_q + (PW+1)'(1);
			else if (pop && !push) fill_q <= fill_q - (PW+1)'(1);
		end
	end

endmodule

// ===== rtl/core/stra_back.sv =====
module stra_back import stra_pkg::*; #(
	parameter int DEPTH  = DEPTH_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  stra_item_t              q_item,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [POS_W-1:0]        max_position,
	output logic signed [VAL_W-1:0] max_value,
	output logic                    range_error
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int LW    = $clog2(LEVELS);
	localparam int CMPW  = (POS_W > CW) ? POS_W : CW;
	localparam int BW    = CW + LEVELS + 1;
	localparam int TBL_N = (LEVELS - 1) * DEPTH;
	localparam int TAW   = $clog2(TBL_N);

	typedef enum logic [2:0] {
		S_IDLE, S_BT_RD, S_BT_VAL, S_BT_WR, S_Q_RD, S_Q_VAL, S_Q_CMP
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic                    ready_q;
	logic [LW-1:0]           lvl_q;
	logic [AW-1:0]           idx_q;
	logic [AW-1:0]           qa_q, qb_q;
	logic [AW-1:0]           pa_q, pb_q;

	// memories: level 0 is implied (entry i holds i), level j sits at row j-1
	logic signed [VAL_W-1:0] val_mem [DEPTH];
	logic [AW-1:0]           tbl_mem [TBL_N];
	logic signed [VAL_W-1:0] val_rd_a_q, val_rd_b_q;
	logic [AW-1:0]           tbl_rd_a_q, tbl_rd_b_q;

	logic [BW-1:0]           span, half;
	logic                    level_done;
	logic                    out_free;
	logic [CMPW-1:0]         right_c, qa_c, qb_c;
	logic                    q_err;
	logic [CW-1:0]           load_base;
	logic                    load_ok;
	logic [AW-1:0]           build_pb;
	logic [LW-1:0]           rd_lvl;
	logic [AW-1:0]           rd_pos_a, rd_pos_b;
	logic [TAW-1:0]          tbl_raddr_a, tbl_raddr_b, tbl_waddr;
	logic                    tbl_we;
	logic [AW-1:0]           pa_sel, pb_sel;
	logic                    pick_a;
	logic [AW-1:0]           best;
	logic [CMPW-1:0]         best_c;

	always_comb begin
		span       = BW'(1) << lvl_q;
		half       = BW'(1) << (lvl_q - LW'(1));
		level_done = (BW'(idx_q) + span) > BW'(count_q);
		out_free   = !out_valid || !out_stall;
		right_c    = CMPW'(q_item.right);
		qa_c       = CMPW'(q_item.pos_a);
		qb_c       = CMPW'(q_item.pos_b);
		q_err      = q_item.bad || !ready_q || (right_c >= CMPW'(count_q));
		load_base  = ready_q ? '0 : count_q;
		load_ok    = load_base < CW'(DEPTH);
		build_pb   = AW'(BW'(idx_q) + half);
		q_pop      = (state_q == S_IDLE) && q_valid &&
		             ((q_item.req_type == REQ_LOAD) || out_free);

		if (state_q == S_Q_RD) begin
			rd_lvl   = lvl_q - LW'(1);
			rd_pos_a = qa_q;
			rd_pos_b = qb_q;
		end else begin
			rd_lvl   = lvl_q - LW'(2);
			rd_pos_a = idx_q;
			rd_pos_b = build_pb;
		end
		tbl_raddr_a = TAW'(32'(rd_lvl) * 32'(DEPTH) + 32'(rd_pos_a));
		tbl_raddr_b = TAW'(32'(rd_lvl) * 32'(DEPTH) + 32'(rd_pos_b));
		tbl_waddr   = TAW'(32'(lvl_q - LW'(1)) * 32'(DEPTH) + 32'(idx_q));
		tbl_we      = state_q == S_BT_WR;

		if (state_q == S_BT_VAL) begin
			pa_sel = (lvl_q == LW'(1)) ? idx_q : tbl_rd_a_q;
			pb_sel = (lvl_q == LW'(1)) ? build_pb : tbl_rd_b_q;
		end else begin
			pa_sel = (lvl_q == '0) ? qa_q : tbl_rd_a_q;
			pb_sel = (lvl_q == '0) ? qb_q : tbl_rd_b_q;
		end

		// ties go right
		pick_a = val_rd_a_q > val_rd_b_q;
		best   = pick_a ? pa_q : pb_q;
		best_c = CMPW'(best);
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_item.req_type == REQ_LOAD) && load_ok)
			val_mem[load_base[AW-1:0]] <= q_item.value;
		val_rd_a_q <= val_mem[pa_sel];
		val_rd_b_q <= val_mem[pb_sel];
	end

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_waddr] <= best;
		tbl_rd_a_q <= tbl_mem[tbl_raddr_a];
		tbl_rd_b_q <= tbl_mem[tbl_raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ready_q      <= 1'b0;
			lvl_q        <= '0;
			idx_q        <= '0;
			qa_q         <= '0;
			qb_q         <= '0;
			pa_q         <= '0;
			pb_q         <= '0;
			out_valid    <= 1'b0;
			max_position <= '0;
			max_value    <= '0;
			range_error  <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						if (q_item.req_type == REQ_LOAD) begin
							ready_q <= 1'b0;
							count_q <= load_ok ? load_base + CW'(1) : load_base;
							if (q_item.last) begin
								lvl_q   <= LW'(1);
								idx_q   <= '0;
								state_q <= S_BT_RD;
							end
						end else if (q_err) begin
							out_valid    <= 1'b1;
							max_position <= '0;
							max_value    <= '0;
							range_error  <= 1'b1;
						end else begin
							lvl_q   <= q_item.lvl[LW-1:0];
							qa_q    <= qa_c[AW-1:0];
							qb_q    <= qb_c[AW-1:0];
							state_q <= S_Q_RD;
						end
					end
				end
				S_BT_RD: begin
					if (level_done) begin
						idx_q <= '0;
						if (lvl_q == LW'(LEVELS - 1)) begin
							ready_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							lvl_q <= lvl_q + LW'(1);
						end
					end else begin
						state_q <= S_BT_VAL;
					end
				end
				S_BT_VAL: begin
					pa_q    <= pa_sel;
					pb_q    <= pb_sel;
					state_q <= S_BT_WR;
				end
				S_BT_WR: begin
					idx_q   <= idx_q + AW'(1);
					state_q <= S_BT_RD;
				end
				S_Q_RD: begin
					state_q <= S_Q_VAL;
				end
				S_Q_VAL: begin
					pa_q    <= pa_sel;
					pb_q    <= pb_sel;
					state_q <= S_Q_CMP;
				end
				S_Q_CMP: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						max_position <= best_c[POS_W-1:0];
						max_value    <= pick_a ? val_rd_a_q : val_rd_b_q;
						range_error  <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/stra_checker.sv =====
module stra_checker import stra_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    req_type,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [POS_W-1:0]        max_position,
	input logic signed [VAL_W-1:0] max_value,
	input logic                    range_error
);

	logic [7:0] pending_q;
	logic       q_in, q_out;

	assign q_in  = in_valid && !in_stall && (req_type == REQ_QUERY);
	assign q_out = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pending_q <= '0;
		else if (q_in && !q_out) pending_q <= pending_q + 8'd1;
		else if (q_out && !q_in) pending_q <= pending_q - 8'd1;
	end

	// a result needs an earlier accepted query
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != '0))
		else $error("result without pending query");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> ((max_position == '0) && (max_value == '0)))
		else $error("error result carries data");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(max_value)))
		else $error("stalled result changed");

endmodule

bind sparse_table_range_argmax stra_checker u_chk (.*);
